FILE: rtl/rife_pkg.sv
`default_nettype none

package rife_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int TICK_BITS_DEF       = 16;
    localparam int INTENSITY_SHIFT_DEF = 4;

    // Fixed field widths
    localparam int RGB_W   = 8;
    localparam int LEVEL_W = 12;
    localparam int TOTAL_W = 16;
    localparam int RAMP_W  = 8;
    localparam int SLICE_W = 8;

    // Register reset and sleep fade length
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd20;
    localparam logic [RAMP_W-1:0]  SLEEP_RAMP  = 8'd2;

    // Sleep sequencing
    typedef enum logic [1:0] {
        PH_AWAKE  = 2'd0,
        PH_FADING = 2'd1,
        PH_ASLEEP = 2'd2
    } t_phase;

    // Launch control for one fade lane
    typedef struct packed {
        logic start;
        logic active;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: rtl/rgb_intensity_fade_engine_unit.sv
`default_nettype none

// Channel  | Direction | Handshake                | Content
// s_*      | in        | i_s_tvalid / o_s_tready  | tick item, tuser = cmd
// m_*      | out       | o_m_tvalid / i_m_tready  | faded colour, intensity, asleep
// cfg_*    | in        | i_cfg_valid / o_cfg_ready| slice_period
//
// One item at a time, taken only in the idle state: the intensity lane runs a
// multiply and a 12-step restoring division, then the three colour lanes run
// the same in parallel, since the colour origin depends on the intensity.
// A clear command skips the lanes and goes to the output register. Synchronous
// active-low reset clears all ramp state; slice_period resets to 20. The next
// item is taken while a result waits in the output register; a stalled output
// holds the engine.

module rgb_intensity_fade_engine_unit #(
    parameter int TICK_BITS       = rife_pkg::TICK_BITS_DEF,
    parameter int INTENSITY_SHIFT = rife_pkg::INTENSITY_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // now_tick, new_command, target_red, target_green, target_blue,
    // target_level, ramp_units, sleep_request, error_present
    input  logic [((TICK_BITS+43+7)/8)*8-1:0] i_s_tdata,
    // cmd
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_red, out_green, out_blue, out_intensity, asleep
    output logic [39:0]                   o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rife_pkg::SLICE_W-1:0]  i_cfg_data
);

    localparam int RW  = rife_pkg::RGB_W;
    localparam int LW  = rife_pkg::LEVEL_W;
    localparam int TW  = rife_pkg::TOTAL_W;
    localparam int SHW = RW + 8;

    localparam int O_NEW = TICK_BITS;
    localparam int O_RED = TICK_BITS + 1;
    localparam int O_GRN = O_RED + RW;
    localparam int O_BLU = O_GRN + RW;
    localparam int O_LVL = O_BLU + RW;
    localparam int O_RMP = O_LVL + RW;
    localparam int O_SLP = O_RMP + rife_pkg::RAMP_W;
    localparam int O_ERR = O_SLP + 1;
    localparam int OUT_W = 40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LVL,
        S_COL,
        S_OUT
    } t_state;

    // Wrap-aware end of ramp: now strictly after start + total, or no length
    function automatic logic f_ramp_over(input logic [TICK_BITS-1:0] now,
                                         input logic [TICK_BITS-1:0] start,
                                         input logic [TW-1:0]        total);
        logic [TICK_BITS-1:0] d;
        d = now - (start + TICK_BITS'(total));
        return (total == '0) || ((d != '0) && !d[TICK_BITS-1]);
    endfunction

    t_state                 r_state;
    logic [rife_pkg::SLICE_W-1:0] r_slice;
    rife_pkg::t_phase       r_phase;

    // Item fields
    logic [TICK_BITS-1:0]   r_now;
    logic                   r_new;
    logic [RW-1:0]          r_tgt [3];
    logic [RW-1:0]          r_level;
    logic [rife_pkg::RAMP_W-1:0] r_ramp;
    logic                   r_sleep;
    logic                   r_err;
    logic                   r_fresh;
    logic [TW-1:0]          r_tot_new;

    // Ramp state
    logic [TICK_BITS-1:0]   r_lvl_start;
    logic [TW-1:0]          r_lvl_total;
    logic                   r_lvl_act;
    logic [LW-1:0]          r_lvl_org;
    logic [TICK_BITS-1:0]   r_col_start;
    logic [TW-1:0]          r_col_total;
    logic                   r_col_act;
    logic [RW-1:0]          r_col_org [3];
    logic [LW-1:0]          r_held_lvl;
    logic [RW-1:0]          r_held_rgb [3];

    // Result and output register
    logic [RW-1:0]          r_res_rgb [3];
    logic [LW-1:0]          r_res_lvl;
    logic                   r_res_asleep;
    logic                   r_m_valid;
    logic [OUT_W-1:0]       r_m_data;

    // Prepare-stage values
    logic                   w_fresh;
    logic [RW-1:0]          w_level;
    logic [rife_pkg::RAMP_W-1:0] w_ramp;
    logic [SHW-1:0]         w_shifted;
    logic [LW-1:0]          w_tlevel;
    logic [TW-1:0]          w_total;
    logic [TICK_BITS-1:0]   w_lvl_start;
    logic [TW-1:0]          w_lvl_total;
    logic [LW-1:0]          w_lvl_org;
    logic                   w_lvl_act;
    rife_pkg::t_phase       w_phase;

    // Colour launch values
    logic [TICK_BITS-1:0]   w_col_start;
    logic [TW-1:0]          w_col_total;
    logic [RW-1:0]          w_col_org [3];
    logic                   w_col_act;

    rife_pkg::t_lane_ctl    w_lvl_ctl;
    rife_pkg::t_lane_ctl    w_col_ctl;
    logic                   w_lvl_done;
    logic [LW-1:0]          w_lvl_res;
    logic                   w_col_done [3];
    logic [LW-1:0]          w_col_res [3];

    logic                   w_s_acc;
    logic                   w_out_free;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    // Apply sleep override and work out the intensity ramp for this item
    always_comb begin
        w_fresh     = r_sleep || r_new;
        w_level     = r_sleep ? '0 : r_level;
        w_ramp      = r_sleep ? (r_err ? '0 : rife_pkg::SLEEP_RAMP) : r_ramp;
        w_shifted   = SHW'(w_level) << INTENSITY_SHIFT;
        w_tlevel    = w_shifted[LW-1:0];
        w_total     = TW'(w_ramp) * TW'(r_slice);
        w_lvl_start = w_fresh ? r_now : r_lvl_start;
        w_lvl_total = w_fresh ? w_total : r_lvl_total;
        w_lvl_org   = w_fresh ? r_held_lvl : r_lvl_org;
        w_lvl_act   = (w_fresh || r_lvl_act) && !f_ramp_over(r_now, w_lvl_start, w_lvl_total);
        if (r_sleep) begin
            w_phase = rife_pkg::PH_FADING;
        end else if (r_new) begin
            w_phase = rife_pkg::PH_AWAKE;
        end else begin
            w_phase = r_phase;
        end
    end

    // Colour ramp, started from the targets when the intensity has gone dark
    always_comb begin
        w_col_start = r_fresh ? r_now : r_col_start;
        w_col_total = r_fresh ? r_tot_new : r_col_total;
        for (int i = 0; i < 3; i++) begin
            w_col_org[i] = r_fresh ? ((w_lvl_res == '0) ? r_tgt[i] : r_held_rgb[i])
                                   : r_col_org[i];
        end
        w_col_act = (r_fresh || r_col_act) && !f_ramp_over(r_now, w_col_start, w_col_total);
    end

    assign w_lvl_ctl.start  = (r_state == S_PREP);
    assign w_lvl_ctl.active = w_lvl_act;
    assign w_col_ctl.start  = (r_state == S_LVL) && w_lvl_done;
    assign w_col_ctl.active = w_col_act;

    rife_fade_lane #(
        .TICK_BITS (TICK_BITS)
    ) u_lvl_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_lvl_ctl),
        .i_target  (w_tlevel),
        .i_origin  (w_lvl_org),
        .i_total   (w_lvl_total),
        .i_elapsed (r_now - w_lvl_start),
        .o_done    (w_lvl_done),
        .o_result  (w_lvl_res)
    );

    for (genvar g = 0; g < 3; g++) begin : g_col
        rife_fade_lane #(
            .TICK_BITS (TICK_BITS)
        ) u_col_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_col_ctl),
            .i_target  (LW'(r_tgt[g])),
            .i_origin  (LW'(w_col_org[g])),
            .i_total   (w_col_total),
            .i_elapsed (r_now - w_col_start),
            .o_done    (w_col_done[g]),
            .o_result  (w_col_res[g])
        );
    end

    // Configuration: one register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= rife_pkg::SLICE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slice <= i_cfg_data;
        end
    end

    // Sequencer, ramp state, merge of lane results and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= rife_pkg::PH_AWAKE;
            r_m_valid   <= 1'b0;
            r_lvl_start <= '0;
            r_lvl_total <= '0;
            r_lvl_act   <= 1'b0;
            r_lvl_org   <= '0;
            r_col_start <= '0;
            r_col_total <= '0;
            r_col_act   <= 1'b0;
            r_held_lvl  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_col_org[i]  <= '0;
                r_held_rgb[i] <= '0;
            end
        end else begin
            // drop the output once the transaction completes and nothing replaces it
            if (r_m_valid && i_m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_now   <= i_s_tdata[TICK_BITS-1:0];
                        r_new   <= i_s_tdata[O_NEW];
                        r_tgt[0] <= i_s_tdata[O_RED +: RW];
                        r_tgt[1] <= i_s_tdata[O_GRN +: RW];
                        r_tgt[2] <= i_s_tdata[O_BLU +: RW];
                        r_level <= i_s_tdata[O_LVL +: RW];
                        r_ramp  <= i_s_tdata[O_RMP +: rife_pkg::RAMP_W];
                        r_sleep <= i_s_tdata[O_SLP];
                        r_err   <= i_s_tdata[O_ERR];
                        if (i_s_tuser) begin
                            // clear held values only
                            r_held_lvl <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_held_rgb[i] <= '0;
                                r_res_rgb[i]  <= '0;
                            end
                            r_res_lvl    <= '0;
                            r_res_asleep <= (r_phase == rife_pkg::PH_ASLEEP);
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_lvl_start <= w_lvl_start;
                    r_lvl_total <= w_lvl_total;
                    r_lvl_org   <= w_lvl_org;
                    r_lvl_act   <= w_lvl_act;
                    r_phase     <= w_phase;
                    r_fresh     <= w_fresh;
                    r_tot_new   <= w_total;
                    r_state     <= S_LVL;
                end
                S_LVL: begin
                    if (w_lvl_done) begin
                        r_held_lvl  <= w_lvl_res;
                        r_res_lvl   <= w_lvl_res;
                        r_col_start <= w_col_start;
                        r_col_total <= w_col_total;
                        r_col_act   <= w_col_act;
                        for (int i = 0; i < 3; i++) begin
                            r_col_org[i] <= w_col_org[i];
                        end
                        if (r_phase == rife_pkg::PH_FADING && w_lvl_res == '0) begin
                            r_phase <= rife_pkg::PH_ASLEEP;
                        end
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    // colour lanes start together and finish together
                    if (w_col_done[0] && w_col_done[1] && w_col_done[2]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_held_rgb[i] <= w_col_res[i][RW-1:0];
                            r_res_rgb[i]  <= w_col_res[i][RW-1:0];
                        end
                        r_res_asleep <= (r_phase == rife_pkg::PH_ASLEEP);
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_m_data  <= OUT_W'({r_res_asleep, r_res_lvl,
                                             r_res_rgb[2], r_res_rgb[1], r_res_rgb[0]});
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/rife_fade_lane.sv
`default_nettype none

module rife_fade_lane #(
    parameter int TICK_BITS = rife_pkg::TICK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rife_pkg::t_lane_ctl          i_ctl,
    input  logic [rife_pkg::LEVEL_W-1:0] i_target,
    input  logic [rife_pkg::LEVEL_W-1:0] i_origin,
    input  logic [rife_pkg::TOTAL_W-1:0] i_total,
    input  logic [TICK_BITS-1:0]         i_elapsed,
    output logic                         o_done,
    output logic [rife_pkg::LEVEL_W-1:0] o_result
);

    localparam int VW = rife_pkg::LEVEL_W;
    localparam int TW = rife_pkg::TOTAL_W;
    localparam int CW = (TICK_BITS > TW) ? TICK_BITS : TW;
    localparam int PW = VW + TW;
    localparam int NW = $clog2(VW);

    typedef enum logic [1:0] {
        L_IDLE,
        L_PREP,
        L_MUL,
        L_DIV
    } t_lstate;

    t_lstate             r_state;
    logic                r_done;
    logic [VW-1:0]       r_result;
    logic [VW-1:0]       r_tgt;
    logic [VW-1:0]       r_org;
    logic [TW-1:0]       r_tot;
    logic [TICK_BITS-1:0] r_ela;
    logic                r_act;
    logic                r_byp;
    logic                r_up;
    logic [VW-1:0]       r_diff;
    logic [TW-1:0]       r_left;
    logic [TW-1:0]       r_rem;
    logic [VW-1:0]       r_quo;
    logic [NW-1:0]       r_cnt;

    logic                n_byp;
    logic                n_up;
    logic [VW-1:0]       n_diff;
    logic [TW-1:0]       n_left;
    logic [PW-1:0]       w_prod;
    logic [TW:0]         w_trial;
    logic                w_fit;
    logic [TW-1:0]       n_rem;
    logic [VW-1:0]       n_quo;
    logic [VW-1:0]       n_res;

    // Ramp bookkeeping, product and one restoring division step
    always_comb begin
        n_byp   = !r_act || (r_tot == '0) || (CW'(r_ela) >= CW'(r_tot));
        n_up    = r_org > r_tgt;
        n_diff  = n_up ? (r_org - r_tgt) : (r_tgt - r_org);
        n_left  = r_tot - TW'(r_ela);
        w_prod  = PW'(r_diff) * PW'(r_left);
        w_trial = {r_rem, r_quo[VW-1]};
        w_fit   = w_trial >= {1'b0, r_tot};
        n_rem   = w_fit ? TW'(w_trial - {1'b0, r_tot}) : w_trial[TW-1:0];
        n_quo   = {r_quo[VW-2:0], w_fit};
        n_res   = r_byp ? r_tgt : (r_up ? (r_tgt + n_quo) : (r_tgt - n_quo));
    end

    // Sequence: latch, prepare, multiply, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            // pulse done with the last quotient bit
            r_done <= (r_state == L_DIV) && (r_cnt == '0);
            case (r_state)
                L_IDLE: begin
                    if (i_ctl.start) begin
                        r_tgt   <= i_target;
                        r_org   <= i_origin;
                        r_tot   <= i_total;
                        r_ela   <= i_elapsed;
                        r_act   <= i_ctl.active;
                        r_state <= L_PREP;
                    end
                end
                L_PREP: begin
                    r_byp   <= n_byp;
                    r_up    <= n_up;
                    r_diff  <= n_diff;
                    r_left  <= n_left;
                    r_state <= L_MUL;
                end
                L_MUL: begin
                    // high part is below the divisor, so the quotient fits VW bits
                    r_rem   <= w_prod[PW-1:VW];
                    r_quo   <= w_prod[VW-1:0];
                    r_cnt   <= NW'(VW - 1);
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_cnt == '0) begin
                        r_result <= n_res;
                        r_state  <= L_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
